FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TWPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that is also checked while reset is asserted.
`define TWPA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/twpa_pkg.sv
// Types and constants shared by the trust-weighted parent acceptance modules.
package twpa_pkg;

  localparam logic [9:0]  TRUST_FULL  = 10'd1000;
  localparam logic [15:0] ETX_MISSING = 16'hffff;
  localparam logic [15:0] COST_CAP    = 16'hffff;
  // Rounding offset of the moving average (half of the denominator ten).
  localparam logic [13:0] AVG_ROUND   = 14'd5;
  // floor(u / 10) == (u * AVG_RECIP) >> AVG_SHIFT for every u below 43690.
  localparam logic [15:0] AVG_RECIP   = 16'd52429;
  localparam int          AVG_SHIFT   = 19;

  typedef enum logic [1:0] {
    CFG_QUEUE_WEIGHT = 2'd0,
    CFG_MIN_TRUST    = 2'd1,
    CFG_MAX_COST     = 2'd2,
    CFG_MAX_ETX      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_EVALUATE = 1'b0,
    OP_OVERRIDE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_DIV,
    B_AVG,
    B_FIN,
    B_WR,
    B_OUT
  } back_state_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [7:0]  node_id;
    logic        in_table;
    logic        present;
    logic [15:0] etx;
    logic [15:0] cost;
    logic [9:0]  ovr_sat;
  } work_item_t;

endpackage

FILE: hdl/trust_weighted_parent_acceptance.sv
// Top level of the trust-weighted parent acceptance block.
// Usage: each input beat is either an evaluate or an override for one
// neighbor. Every input beat yields exactly one result beat, in order.
// Both data channels use valid and stall; a beat moves when valid is high
// and stall is low. Configuration writes arrive on the cfg_ channel, which
// is always ready, and should only be issued while the block is idle.
// An evaluate whose trust sample needs the divider runs the serial
// restoring divider over NW quotient bits, where NW is the bit width of
// 1000 * ETX_DIVISOR (17 at the default); a first sample skips the
// averaging step. Other items (override, missing stats, out-of-table node,
// tiny or missing ETX) skip the divider. The divider in the back end sets
// the rate: one item is worked on at a time, while the front end and a
// two-entry queue keep accepting beats ahead of it.
// Reset clears the configuration to its defaults and clears all seen
// marks at once, so every trust entry starts out unseen; no clearing pass.
// When the receiver stalls, the result register holds its beat, the back
// end waits, the queue fills and finally in_stall rises.
module trust_weighted_parent_acceptance import twpa_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int ETX_DIVISOR   = 128,
  parameter int QUEUE_SLOTS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_node_id,
  input  logic        in_stats_present,
  input  logic [15:0] in_link_etx,
  input  logic [15:0] in_neighbor_rank,
  input  logic [3:0]  in_queue_free,
  input  logic [15:0] in_override_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [9:0]  out_trust_value,
  output logic [15:0] out_path_cost,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] queue_weight_r;
  logic [9:0]  min_trust_r;
  logic [15:0] max_cost_r;
  logic [15:0] max_etx_r;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_nonempty;
  work_item_t  push_item;
  work_item_t  pop_item;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_weight_r <= 16'd32;
      min_trust_r    <= 10'd700;
      max_cost_r     <= 16'd60000;
      max_etx_r      <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUEUE_WEIGHT: queue_weight_r <= cfg_data;
        CFG_MIN_TRUST:    min_trust_r    <= cfg_data[9:0];
        CFG_MAX_COST:     max_cost_r     <= cfg_data;
        CFG_MAX_ETX:      max_etx_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end accepts the beat and computes the saturated path cost.
  twpa_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .QUEUE_SLOTS  (QUEUE_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_node_id       (in_node_id),
    .in_stats_present (in_stats_present),
    .in_link_etx      (in_link_etx),
    .in_neighbor_rank (in_neighbor_rank),
    .in_queue_free    (in_queue_free),
    .in_override_value(in_override_value),
    .queue_weight     (queue_weight_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  twpa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_item (pop_item)
  );

  // The back end runs the divider, updates the trust store and drives results.
  twpa_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ETX_DIVISOR  (ETX_DIVISOR)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .min_parent_trust(min_trust_r),
    .max_path_cost   (max_cost_r),
    .max_link_etx    (max_etx_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_trust_value (out_trust_value),
    .out_path_cost   (out_path_cost)
  );

endmodule

FILE: hdl/twpa_front.sv
// Front end: accepts input beats, classifies them and forms the path cost.
module twpa_front import twpa_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int QUEUE_SLOTS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_node_id,
  input  logic        in_stats_present,
  input  logic [15:0] in_link_etx,
  input  logic [15:0] in_neighbor_rank,
  input  logic [3:0]  in_queue_free,
  input  logic [15:0] in_override_value,
  input  logic [15:0] queue_weight,
  input  logic        q_full,
  output logic        q_push,
  output work_item_t  q_item
);

  logic        hold_valid_r, hold_valid_nxt;
  logic        op_r;
  logic [7:0]  id_r;
  logic        present_r;
  logic [15:0] etx_r;
  logic [15:0] rank_r;
  logic [3:0]  free_r;
  logic [15:0] ovr_r;
  logic        accept;
  logic [6:0]  slots;
  logic [6:0]  free_ext;
  logic [6:0]  used;
  logic [22:0] pen;
  logic [15:0] pen_sat;
  logic [15:0] etx_eff;
  logic [17:0] sum;

  assign in_stall       = hold_valid_r & q_full;
  assign accept         = in_valid & ~in_stall;
  assign q_push         = hold_valid_r & ~q_full;
  assign hold_valid_nxt = accept | (hold_valid_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      id_r      <= in_node_id;
      present_r <= in_stats_present;
      etx_r     <= in_link_etx;
      rank_r    <= in_neighbor_rank;
      free_r    <= in_queue_free;
      ovr_r     <= in_override_value;
    end
  end

  always_comb begin
    slots    = 7'(QUEUE_SLOTS);
    free_ext = {3'b000, free_r};
    used     = (free_ext < slots) ? (slots - free_ext) : 7'd0;
    pen      = {16'd0, used} * {7'd0, queue_weight};
    pen_sat  = (|pen[22:16]) ? COST_CAP : pen[15:0];
    etx_eff  = present_r ? etx_r : ETX_MISSING;
    sum      = {2'b00, rank_r} + {2'b00, etx_eff} + {2'b00, pen_sat};

    q_item.op       = op_t'(op_r);
    q_item.node_id  = id_r;
    q_item.in_table = ({1'b0, id_r} < 9'(TABLE_ENTRIES));
    q_item.present  = present_r;
    q_item.etx      = etx_eff;
    q_item.cost     = (|sum[17:16]) ? COST_CAP : sum[15:0];
    q_item.ovr_sat  = (ovr_r > {6'd0, TRUST_FULL}) ? TRUST_FULL : ovr_r[9:0];
  end

endmodule

FILE: hdl/twpa_queue.sv
// Two-entry queue of classified items between the front and the back.
module twpa_queue import twpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  work_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       nonempty,
  output work_item_t pop_item
);

  work_item_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/twpa_back.sv
// Back end: trust sample divider, trust store update and result register.
module twpa_back import twpa_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int ETX_DIVISOR   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  work_item_t  q_item,
  output logic        q_pop,
  input  logic [9:0]  min_parent_trust,
  input  logic [15:0] max_path_cost,
  input  logic [15:0] max_link_etx,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [9:0]  out_trust_value,
  output logic [15:0] out_path_cost
);

  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NUM = 1000 * ETX_DIVISOR;
  localparam int NW  = $clog2(NUM + 1);
  localparam int CW  = $clog2(NW + 1);

  back_state_t st_r, st_nxt;
  work_item_t  it_r, it_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [9:0]  samp_r, samp_nxt;
  logic [29:0] prod_r, prod_nxt;
  logic [9:0]  trust_r, trust_nxt;
  logic        seen_hit_r, seen_hit_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_acc_r, out_acc_nxt;
  logic [9:0]  out_trust_r, out_trust_nxt;
  logic [15:0] out_cost_r, out_cost_nxt;

  logic [9:0]  mem [TABLE_ENTRIES];
  logic [9:0]  rd_r;
  logic [TABLE_ENTRIES-1:0] seen_r;
  logic [IW-1:0] addr;
  logic        we;
  logic [9:0]  wdata;
  logic [16:0] rem_sh;
  logic        q_bit;
  logic [13:0] avg_sum;

  assign addr            = it_r.node_id[IW-1:0];
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_trust_value = out_trust_r;
  assign out_path_cost   = out_cost_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (we) begin
      seen_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r        <= it_nxt;
    rem_r       <= rem_nxt;
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    samp_r      <= samp_nxt;
    prod_r      <= prod_nxt;
    trust_r     <= trust_nxt;
    seen_hit_r  <= seen_hit_nxt;
    out_acc_r   <= out_acc_nxt;
    out_trust_r <= out_trust_nxt;
    out_cost_r  <= out_cost_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    it_nxt        = it_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    samp_nxt      = samp_r;
    prod_nxt      = prod_r;
    trust_nxt     = trust_r;
    seen_hit_nxt  = seen_hit_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_acc_nxt   = out_acc_r;
    out_trust_nxt = out_trust_r;
    out_cost_nxt  = out_cost_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wdata         = trust_r;
    rem_sh        = {rem_r, num_r[NW-1]};
    q_bit         = (rem_sh >= {1'b0, it_r.etx});
    avg_sum       = {3'd0, samp_r, 1'b0} + {1'b0, rd_r, 3'd0} + AVG_ROUND;

    unique case (st_r)
      B_IDLE: begin
        if (q_nonempty) begin
          q_pop  = 1'b1;
          it_nxt = q_item;
          st_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        seen_hit_nxt = seen_r[addr];
        if (it_r.op == OP_OVERRIDE) begin
          we        = it_r.in_table;
          wdata     = it_r.ovr_sat;
          trust_nxt = it_r.ovr_sat;
          st_nxt    = B_OUT;
        end else if (!it_r.present || !it_r.in_table) begin
          trust_nxt = TRUST_FULL;
          st_nxt    = B_OUT;
        end else if ({1'b0, it_r.etx} <= 17'(ETX_DIVISOR)) begin
          samp_nxt = TRUST_FULL;
          st_nxt   = B_AVG;
        end else if (it_r.etx == ETX_MISSING) begin
          samp_nxt = 10'd0;
          st_nxt   = B_AVG;
        end else begin
          rem_nxt = 16'd0;
          num_nxt = NW'(NUM);
          quo_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt = q_bit ? 16'(rem_sh - {1'b0, it_r.etx}) : rem_sh[15:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
        quo_nxt = {quo_r[NW-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          samp_nxt = quo_nxt[9:0];
          st_nxt   = B_AVG;
        end
      end
      B_AVG: begin
        if (seen_hit_r) begin
          prod_nxt = {16'd0, avg_sum} * {14'd0, AVG_RECIP};
          st_nxt   = B_FIN;
        end else begin
          trust_nxt = samp_r;
          st_nxt    = B_WR;
        end
      end
      B_FIN: begin
        trust_nxt = prod_r[AVG_SHIFT +: 10];
        st_nxt    = B_WR;
      end
      B_WR: begin
        we     = 1'b1;
        wdata  = trust_r;
        st_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_trust_nxt = trust_r;
          if (it_r.op == OP_OVERRIDE) begin
            out_acc_nxt  = 1'b0;
            out_cost_nxt = 16'd0;
          end else begin
            out_acc_nxt  = (it_r.etx <= max_link_etx) && (it_r.cost <= max_path_cost) &&
                           (trust_r >= min_parent_trust);
            out_cost_nxt = it_r.cost;
          end
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

endmodule

FILE: hdl/twpa_checker.sv
// Port-level checker for the trust-weighted parent acceptance block.
`include "assert_macros.svh"

module twpa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_trust_value,
  input logic       cfg_ready
);

  `TWPA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
  `TWPA_ASSERT(a_trust_range, out_valid |-> out_trust_value <= 10'd1000, "trust beyond full scale")
  `TWPA_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result beat right after reset")
  `TWPA_ASSERT(a_cfg_ready, $past(rst_n) |-> cfg_ready, "register port not ready")

endmodule

bind trust_weighted_parent_acceptance twpa_checker u_twpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_trust_value(out_trust_value),
  .cfg_ready      (cfg_ready)
);
